### sv/whpwl_pkg.sv
// ----------------------------------------------------------------------------
// whpwl_pkg
// Shared types, widths and codes for the weighted HPWL accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package whpwl_pkg;

    localparam int MAX_CENTERS = 1024;
    localparam int COORD_BITS  = 32;

    localparam int ADDR_W   = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int COORD_XW = (COORD_BITS > 32) ? COORD_BITS : 32;
    localparam int SPAN_W   = COORD_BITS + 2;
    localparam int WEIGHT_W = 16;
    localparam int PROD_W   = SPAN_W + WEIGHT_W;
    localparam int PROD_XW  = (PROD_W > 65) ? PROD_W : 65;
    localparam int COUNT_W  = 11;
    localparam int INDEX_W  = 11;
    localparam int TOTAL_W  = 63;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_PIN  = 2'd1;
    localparam logic [1:0] FUNC_END  = 2'd2;

    typedef struct packed {
        logic [1:0]          func;
        logic [INDEX_W-1:0]  item_index;
        logic signed [31:0]  coord_x;
        logic signed [31:0]  coord_y;
        logic [WEIGHT_W-1:0] net_weight;
        logic                net_last;
    } t_in_word;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_wirelength;
        logic               saturated;
    } t_out_word;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_PIN,
        OP_END
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic [ADDR_W-1:0]          addr;
        logic                       pin_ok;
        logic                       last;
        logic [WEIGHT_W-1:0]        weight;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOX,
        ST_SPAN,
        ST_MUL,
        ST_ACC
    } t_back_state;

endpackage

`default_nettype wire

### sv/whpwl_front.sv
// ----------------------------------------------------------------------------
// whpwl_front
// Accepts input words, range-checks indices against the table size (and, for
// pins, the center count) and queues the words that have an effect.
// ----------------------------------------------------------------------------
`default_nettype none

module whpwl_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire whpwl_pkg::t_in_word         i_in_word,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [whpwl_pkg::COUNT_W-1:0] i_cfg_data,
    input  wire whpwl_pkg::t_q_status        i_q_status,
    output logic                             o_push,
    output whpwl_pkg::t_cmd                  o_cmd
);
    import whpwl_pkg::*;

    logic [COUNT_W-1:0]         r_count;
    logic                       w_in_range;
    logic                       w_below_count;
    logic                       w_keep;
    logic signed [COORD_XW-1:0] w_x_ext;
    logic signed [COORD_XW-1:0] w_y_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    assign w_in_range    = 32'(i_in_word.item_index) < 32'(MAX_CENTERS);
    assign w_below_count = 32'(i_in_word.item_index) < 32'(r_count);

    always_comb begin
        w_keep = 1'b0;
        unique case (i_in_word.func)
            FUNC_LOAD: w_keep = w_in_range;
            FUNC_PIN:  w_keep = (w_in_range && w_below_count) || i_in_word.net_last;
            FUNC_END:  w_keep = 1'b1;
            default:   w_keep = 1'b0;
        endcase
    end

    assign w_x_ext = COORD_XW'(i_in_word.coord_x);
    assign w_y_ext = COORD_XW'(i_in_word.coord_y);

    always_comb begin
        o_cmd.op = OP_END;
        unique case (i_in_word.func)
            FUNC_LOAD: o_cmd.op = OP_LOAD;
            FUNC_PIN:  o_cmd.op = OP_PIN;
            default:   o_cmd.op = OP_END;
        endcase
        o_cmd.addr   = ADDR_W'(i_in_word.item_index);
        o_cmd.pin_ok = w_in_range && w_below_count;
        o_cmd.last   = i_in_word.net_last;
        o_cmd.weight = i_in_word.net_weight;
        o_cmd.x      = w_x_ext[COORD_BITS-1:0];
        o_cmd.y      = w_y_ext[COORD_BITS-1:0];
    end

    assign o_in_ready = !i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full && w_keep;

endmodule

`default_nettype wire

### sv/whpwl_fifo.sv
// ----------------------------------------------------------------------------
// whpwl_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module whpwl_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire whpwl_pkg::t_cmd  i_cmd,
    input  wire logic             i_pop,
    output whpwl_pkg::t_cmd       o_cmd,
    output whpwl_pkg::t_q_status  o_status
);
    import whpwl_pkg::*;

    t_cmd            r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_fill;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fill <= r_fill + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

    assign o_cmd          = r_slot[r_rd_ptr];
    assign o_status.full  = r_fill == (Q_AW+1)'(Q_DEPTH);
    assign o_status.empty = r_fill == '0;

endmodule

`default_nettype wire

### sv/whpwl_back.sv
// ----------------------------------------------------------------------------
// whpwl_back
// Executes queued commands: center table writes and reads, bounding box,
// weighted span accumulate and total output register.
// ----------------------------------------------------------------------------
`default_nettype none

module whpwl_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire whpwl_pkg::t_cmd  i_cmd,
    input  wire whpwl_pkg::t_q_status i_q_status,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output whpwl_pkg::t_out_word  o_out_word
);
    import whpwl_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic [2*COORD_BITS-1:0]      r_mem [MAX_CENTERS];
    logic [2*COORD_BITS-1:0]      r_rd_data;
    logic signed [COORD_BITS-1:0] w_rd_x;
    logic signed [COORD_BITS-1:0] w_rd_y;

    logic signed [COORD_BITS-1:0] r_min_x;
    logic signed [COORD_BITS-1:0] r_max_x;
    logic signed [COORD_BITS-1:0] r_min_y;
    logic signed [COORD_BITS-1:0] r_max_y;
    logic                         r_has_pin;
    logic                         r_pin_ok;
    logic                         r_last;
    logic [WEIGHT_W-1:0]          r_weight;
    logic                         r_net;
    logic [SPAN_W-1:0]            r_span;
    logic [PROD_W-1:0]            r_prod;
    logic [TOTAL_W-1:0]           r_total;
    logic                         r_clipped;
    logic                         r_out_valid;
    t_out_word                    r_out_word;

    logic                         w_out_free;
    logic                         w_do_load;
    logic                         w_do_read;
    logic                         w_do_end;
    logic [COORD_BITS:0]          w_dx;
    logic [COORD_BITS:0]          w_dy;
    logic [PROD_XW-1:0]           w_prod_x;
    logic                         w_prod_ovf;
    logic [63:0]                  w_sum;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        w_do_load = 1'b0;
        w_do_read = 1'b0;
        w_do_end  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    unique case (i_cmd.op)
                        OP_LOAD: begin
                            o_pop     = 1'b1;
                            w_do_load = 1'b1;
                        end
                        OP_PIN: begin
                            o_pop     = 1'b1;
                            w_do_read = 1'b1;
                            n_state   = ST_BOX;
                        end
                        default: begin
                            if (w_out_free) begin
                                o_pop    = 1'b1;
                                w_do_end = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_BOX:  n_state = r_last ? ST_SPAN : ST_IDLE;
            ST_SPAN: n_state = ST_MUL;
            ST_MUL:  n_state = ST_ACC;
            ST_ACC:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_do_load) begin
            r_mem[i_cmd.addr] <= {i_cmd.x, i_cmd.y};
        end
        if (w_do_read) begin
            r_rd_data <= r_mem[i_cmd.addr];
        end
    end

    assign w_rd_x = r_rd_data[2*COORD_BITS-1:COORD_BITS];
    assign w_rd_y = r_rd_data[COORD_BITS-1:0];

    assign w_dx = (COORD_BITS+1)'(r_max_x) - (COORD_BITS+1)'(r_min_x);
    assign w_dy = (COORD_BITS+1)'(r_max_y) - (COORD_BITS+1)'(r_min_y);

    assign w_prod_x   = PROD_XW'(r_prod);
    assign w_prod_ovf = |w_prod_x[PROD_XW-1:64];
    assign w_sum      = {1'b0, r_total} + 64'(w_prod_x[63:8]);

    always_ff @(posedge i_clk) begin
        if (w_do_read) begin
            r_pin_ok <= i_cmd.pin_ok;
            r_last   <= i_cmd.last;
            r_weight <= i_cmd.weight;
        end
        if (r_state == ST_BOX && r_pin_ok) begin
            if (!r_has_pin) begin
                r_min_x <= w_rd_x;
                r_max_x <= w_rd_x;
                r_min_y <= w_rd_y;
                r_max_y <= w_rd_y;
            end else begin
                if (w_rd_x < r_min_x) r_min_x <= w_rd_x;
                if (w_rd_x > r_max_x) r_max_x <= w_rd_x;
                if (w_rd_y < r_min_y) r_min_y <= w_rd_y;
                if (w_rd_y > r_max_y) r_max_y <= w_rd_y;
            end
        end
        if (r_state == ST_SPAN) begin
            r_span <= SPAN_W'(w_dx) + SPAN_W'(w_dy);
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'(r_span) * PROD_W'(r_weight);
        end
        if (w_do_end) begin
            r_out_word.total_wirelength <= r_total;
            r_out_word.saturated        <= r_clipped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_pin   <= 1'b0;
            r_net       <= 1'b0;
            r_total     <= '0;
            r_clipped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_BOX && r_pin_ok) begin
                r_has_pin <= 1'b1;
            end
            if (r_state == ST_SPAN) begin
                r_net     <= r_has_pin;
                r_has_pin <= 1'b0;
            end
            if (r_state == ST_ACC && r_net) begin
                if (w_prod_ovf || r_clipped || w_sum[63]) begin
                    r_total   <= TOTAL_MAX;
                    r_clipped <= 1'b1;
                end else begin
                    r_total <= w_sum[TOTAL_W-1:0];
                end
            end
            if (w_do_end) begin
                r_total     <= '0;
                r_clipped   <= 1'b0;
                r_has_pin   <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_clip_holds_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clipped |-> r_total == TOTAL_MAX)
        else $error("clip flag set with total below maximum");

    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_end |=> r_out_valid && !r_clipped && r_total == '0)
        else $error("end word did not emit and clear the total");

    a_span_clears_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SPAN |=> !r_has_pin && r_state == ST_MUL)
        else $error("net close did not clear the box");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_status.empty && r_state == ST_IDLE)
        else $error("pop from empty queue or busy back end");

endmodule

`default_nettype wire

### sv/weighted_hpwl_accumulator.sv
// ----------------------------------------------------------------------------
// weighted_hpwl_accumulator
// Weighted half-perimeter wirelength: loads cell centers, builds net bounding
// boxes from pin words, sums (weight * half-perimeter) >> 8, emits the total.
//
//   channel   dir  handshake                    payload
//   in        in   i_in_valid / o_in_ready      i_in_word  (t_in_word)
//   out       out  o_out_valid / i_out_ready    o_out_word (t_out_word)
//   cfg       in   i_cfg_valid / o_cfg_ready    i_cfg_data (center count)
//
// Back end steps per word: load and end are handled in the idle state; a pin
// does a table read and box update; the last pin adds span, multiply, saturating add.
// A four-entry queue lets the input side run ahead of the back end.
// Reset is synchronous, active low; the center table is not cleared.
// An end word waits in the queue while the output register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_hpwl_accumulator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire whpwl_pkg::t_in_word           i_in_word,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output whpwl_pkg::t_out_word               o_out_word,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [whpwl_pkg::COUNT_W-1:0] i_cfg_data
);
    import whpwl_pkg::*;

    t_q_status w_q_status;
    t_cmd      w_push_cmd;
    t_cmd      w_head_cmd;
    logic      w_push;
    logic      w_pop;

    whpwl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    whpwl_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_head_cmd),
        .o_status (w_q_status)
    );

    whpwl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_head_cmd),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire
